[rtl/ps2_mouse_packet_event_queue_core_assert.svh]
// ----------------------------------------------------------------------------
// PS/2 mouse event queue assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled during rst.
// ----------------------------------------------------------------------------
`ifndef PS2_MOUSE_PACKET_EVENT_QUEUE_CORE_ASSERT_SVH
`define PS2_MOUSE_PACKET_EVENT_QUEUE_CORE_ASSERT_SVH

// same-cycle implication
`define PS2MQ_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ps2mq assertion failed");

// next-cycle implication
`define PS2MQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ps2mq assertion failed");

`endif

[rtl/ps2mq_pkg.sv]
// ----------------------------------------------------------------------------
// ps2mq_pkg
// Types and constants for the PS/2 mouse packet event queue.
// ----------------------------------------------------------------------------
package ps2mq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);

  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_READ = 1'b1;

  localparam logic [1:0] PHASE_FIRST  = 2'd0;
  localparam logic [1:0] PHASE_SECOND = 2'd1;
  localparam logic [1:0] PHASE_THIRD  = 2'd2;

  typedef logic [IDX_W-1:0] idx_t;

  typedef struct packed {
    logic [2:0]        buttons;
    logic [2:0]        prev_buttons;
    logic signed [8:0] move_y;
    logic signed [8:0] move_x;
  } event_t;

  typedef struct packed {
    logic   push;
    idx_t   wr_idx;
    event_t entry;
    logic   rd_en;
    idx_t   rd_idx;
    logic   read_hit;
    logic   is_read;
  } ctrl_req_t;

  typedef struct packed {
    logic [2:0]        buttons;
    logic [2:0]        prev_buttons;
    logic signed [8:0] move_y;
    logic signed [8:0] move_x;
    logic              event_pushed;
    logic              event_valid;
  } result_t;

  function automatic idx_t next_index(idx_t i);
    if (i == idx_t'(QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return i + idx_t'(1);
  endfunction

endpackage

[rtl/ps2mq_ring.sv]
// ----------------------------------------------------------------------------
// ps2mq_ring
// Event ring storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
module ps2mq_ring (
  input  logic              clk,
  input  logic              wr_en,
  input  ps2mq_pkg::idx_t   wr_idx,
  input  ps2mq_pkg::event_t wr_data,
  input  logic              rd_en,
  input  ps2mq_pkg::idx_t   rd_idx,
  output ps2mq_pkg::event_t rd_data
);

  ps2mq_pkg::event_t mem [ps2mq_pkg::QUEUE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_idx];
    end
  end

endmodule

[rtl/ps2mq_ctrl.sv]
// ----------------------------------------------------------------------------
// ps2mq_ctrl
// Packet framing, motion decode and ring pointer control.
// ----------------------------------------------------------------------------
`include "ps2_mouse_packet_event_queue_core_assert.svh"

module ps2mq_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  logic                 kind,
  input  logic [7:0]           ctrl_status,
  input  logic [7:0]           data_byte,
  output ps2mq_pkg::ctrl_req_t req
);

  logic [1:0]      packet_phase, packet_phase_next;
  logic [7:0]      first_byte, first_byte_next;
  logic [7:0]      second_byte, second_byte_next;
  logic [2:0]      last_buttons, last_buttons_next;
  ps2mq_pkg::idx_t ring_head, ring_head_next;
  ps2mq_pkg::idx_t ring_tail, ring_tail_next;
  logic            ring_ready, ring_ready_next;

  logic              byte_ok;
  logic signed [8:0] mx, my_raw, my;
  logic [2:0]        btn;
  logic              want_push;
  ps2mq_pkg::idx_t   tail_adv;

  always_comb begin
    byte_ok = ctrl_status[0] && ctrl_status[5];
    btn     = first_byte[2:0];
    mx      = {first_byte[4] && (second_byte != 8'd0), second_byte};
    my_raw  = {first_byte[5] && (data_byte != 8'd0), data_byte};
    if (first_byte[7:6] != 2'b00) begin
      mx     = '0;
      my_raw = '0;
    end
    my        = -my_raw;
    want_push = (mx != 9'sd0) || (my != 9'sd0) || (btn != 3'd0) || (btn != last_buttons);
    tail_adv  = ps2mq_pkg::next_index(ring_tail);
  end

  always_comb begin
    packet_phase_next = packet_phase;
    first_byte_next   = first_byte;
    second_byte_next  = second_byte;
    last_buttons_next = last_buttons;
    ring_head_next    = ring_head;
    ring_tail_next    = ring_tail;
    ring_ready_next   = ring_ready;

    req                    = '0;
    req.rd_en              = accept;
    req.rd_idx             = ring_head;
    req.is_read            = (kind == ps2mq_pkg::KIND_READ);
    req.entry.move_x       = mx;
    req.entry.move_y       = my;
    req.entry.prev_buttons = last_buttons;
    req.entry.buttons      = btn;
    req.wr_idx             = ring_tail;

    if (accept) begin
      if (kind == ps2mq_pkg::KIND_READ) begin
        if (ring_ready) begin
          req.read_hit = 1'b1;
          if (ring_tail != ring_head) begin
            ring_head_next = ps2mq_pkg::next_index(ring_head);
          end else begin
            ring_ready_next = 1'b0;
          end
        end
      end else if (byte_ok) begin
        unique case (packet_phase)
          ps2mq_pkg::PHASE_SECOND: begin
            second_byte_next  = data_byte;
            packet_phase_next = ps2mq_pkg::PHASE_THIRD;
          end
          ps2mq_pkg::PHASE_THIRD: begin
            packet_phase_next = ps2mq_pkg::PHASE_FIRST;
            last_buttons_next = btn;
            if (want_push) begin
              req.push        = 1'b1;
              ring_ready_next = 1'b1;
              if (ring_ready) begin
                req.wr_idx     = tail_adv;
                ring_tail_next = tail_adv;
                if (tail_adv == ring_head) begin
                  ring_head_next = ps2mq_pkg::next_index(ring_head);
                end
              end else begin
                ring_head_next = ring_tail;
              end
            end
          end
          default: begin
            first_byte_next   = data_byte;
            packet_phase_next = data_byte[3] ? ps2mq_pkg::PHASE_SECOND
                                             : ps2mq_pkg::PHASE_FIRST;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      packet_phase <= ps2mq_pkg::PHASE_FIRST;
      first_byte   <= '0;
      second_byte  <= '0;
      last_buttons <= '0;
      ring_head    <= '0;
      ring_tail    <= '0;
      ring_ready   <= 1'b0;
    end else begin
      packet_phase <= packet_phase_next;
      first_byte   <= first_byte_next;
      second_byte  <= second_byte_next;
      last_buttons <= last_buttons_next;
      ring_head    <= ring_head_next;
      ring_tail    <= ring_tail_next;
      ring_ready   <= ring_ready_next;
    end
  end

  `PS2MQ_ASSERT_NOW(a_empty_ptrs, !ring_ready, ring_head == ring_tail)
  `PS2MQ_ASSERT_NEXT(a_push_ready, req.push, ring_ready)
  `PS2MQ_ASSERT_NEXT(a_read_adv, req.read_hit && (ring_head != ring_tail),
    ring_head == ps2mq_pkg::next_index($past(ring_head)) && ring_ready)

endmodule

[rtl/ps2mq_skid.sv]
// ----------------------------------------------------------------------------
// ps2mq_skid
// Two-entry output skid buffer with a registered ready.
// ----------------------------------------------------------------------------
module ps2mq_skid (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  ps2mq_pkg::result_t in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output ps2mq_pkg::result_t out_data
);

  logic               main_valid;
  ps2mq_pkg::result_t main_data;
  logic               spare_valid;
  ps2mq_pkg::result_t spare_data;
  logic               in_fire;

  assign in_ready  = !spare_valid;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = main_valid;
  assign out_data  = main_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid  <= 1'b0;
      spare_valid <= 1'b0;
    end else if (!main_valid || out_ready) begin
      if (spare_valid) begin
        main_valid  <= 1'b1;
        spare_valid <= 1'b0;
      end else begin
        main_valid <= in_fire;
      end
    end else if (in_fire) begin
      spare_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!main_valid || out_ready) begin
      main_data <= spare_valid ? spare_data : in_data;
    end else if (in_fire) begin
      spare_data <= in_data;
    end
  end

endmodule

[rtl/ps2_mouse_packet_event_queue_core.sv]
// ----------------------------------------------------------------------------
// ps2_mouse_packet_event_queue_core
// PS/2 mouse three-byte packet decoder feeding a 16-entry overwrite ring.
// ----------------------------------------------------------------------------
// One item per cycle, sustained while the output skid has room; s_tready drops
// when it is full. An accepted item updates framing and ring pointers and issues
// the ring read in its accept cycle; its result is held in the ring read register
// and then passes a two-entry output skid. A read of an empty ring and
// a byte that does not complete a queued packet return an all-zero result.
module ps2_mouse_packet_event_queue_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // ctrl_status[7:0], data_byte[15:8]
  input  logic        s_tuser,   // kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // event_valid[0], event_pushed[1], move_x[10:2],
                                 // move_y[19:11], prev_buttons[22:20],
                                 // buttons[25:23], zero[31:26]
);

  logic                 accept;
  ps2mq_pkg::ctrl_req_t req;
  ps2mq_pkg::event_t    rd_data;

  logic                 s1_valid;
  logic                 s1_is_read;
  logic                 s1_hit;
  ps2mq_pkg::event_t    s1_entry;
  logic                 skid_ready;
  ps2mq_pkg::result_t   s1_result;
  ps2mq_pkg::result_t   out_result;

  assign s_tready = !s1_valid || skid_ready;
  assign accept   = s_tvalid && s_tready;

  ps2mq_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .kind        (s_tuser),
    .ctrl_status (s_tdata[7:0]),
    .data_byte   (s_tdata[15:8]),
    .req         (req)
  );

  ps2mq_ring u_ring (
    .clk     (clk),
    .wr_en   (req.push),
    .wr_idx  (req.wr_idx),
    .wr_data (req.entry),
    .rd_en   (req.rd_en),
    .rd_idx  (req.rd_idx),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_is_read <= req.is_read;
      s1_hit     <= req.is_read ? req.read_hit : req.push;
      s1_entry   <= req.entry;
    end
  end

  always_comb begin
    s1_result = '0;
    if (s1_hit) begin
      if (s1_is_read) begin
        s1_result.event_valid  = 1'b1;
        s1_result.move_x       = rd_data.move_x;
        s1_result.move_y       = rd_data.move_y;
        s1_result.prev_buttons = rd_data.prev_buttons;
        s1_result.buttons      = rd_data.buttons;
      end else begin
        s1_result.event_pushed = 1'b1;
        s1_result.move_x       = s1_entry.move_x;
        s1_result.move_y       = s1_entry.move_y;
        s1_result.prev_buttons = s1_entry.prev_buttons;
        s1_result.buttons      = s1_entry.buttons;
      end
    end
  end

  ps2mq_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s1_valid),
    .in_ready  (skid_ready),
    .in_data   (s1_result),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_result)
  );

  assign m_tdata = {6'd0, out_result};

endmodule
